// ===== rtl/tgd_pkg.sv =====
`default_nettype none
package tgd_pkg;

  localparam int TGD_TILE_BYTES = 32;
  localparam int TGD_TILE_AW    = $clog2(TGD_TILE_BYTES);
  localparam int TGD_SUB_DEPTH  = 256;
  localparam int TGD_BYTE_W     = 8;

  localparam logic [TGD_TILE_AW-1:0] TGD_LAST_POS = TGD_TILE_AW'(TGD_TILE_BYTES - 1);

  // Operation codes of an input beat.
  localparam logic [1:0] OP_TILE_CMD  = 2'd0;
  localparam logic [1:0] OP_DATA      = 2'd1;
  localparam logic [1:0] OP_TABLE_WR  = 2'd2;

  // Tile command codes.
  localparam logic [1:0] CMD_ZERO     = 2'd0;
  localparam logic [1:0] CMD_LITERAL  = 2'd1;
  localparam logic [1:0] CMD_MASKED   = 2'd2;
  localparam logic [1:0] CMD_MASK_XOR = 2'd3;

  localparam logic [2:0] MASK_BYTES   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SKIP,
    ST_EMIT
  } tgd_state_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_READ,
    E_CALC,
    E_LOAD,
    E_HOLD
  } tgd_emit_state_t;

  typedef struct packed {
    logic                  we;
    logic [7:0]            addr;
    logic [TGD_BYTE_W-1:0] data;
  } tgd_sub_wr_t;

  typedef struct packed {
    logic                      start;
    logic [1:0]                mode;
    logic [TGD_TILE_BYTES-1:0] mask;
  } tgd_emit_req_t;

endpackage
`default_nettype wire

// ===== rtl/tgd_ram.sv =====
`default_nettype none
module tgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tgd_emit.sv =====
`default_nettype none
module tgd_emit
  import tgd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire tgd_emit_req_t          req,
  input  wire tgd_sub_wr_t            sub_wr,
  input  wire logic                   sub_enable,
  output logic                        busy,
  output logic                        tile_rd_en,
  output logic [TGD_TILE_AW-1:0]      tile_rd_addr,
  input  wire logic [TGD_BYTE_W-1:0]  tile_rd_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [TGD_BYTE_W-1:0]       out_tile_byte,
  output logic [TGD_TILE_AW-1:0]      out_byte_index,
  output logic                        out_last_of_tile
);

  tgd_emit_state_t state_r, state_nxt;

  logic [TGD_TILE_AW-1:0]    pos_r, pos_nxt;
  logic [1:0]                mode_r, mode_nxt;
  logic [TGD_TILE_BYTES-1:0] mask_r, mask_nxt;
  logic [TGD_BYTE_W-1:0]     val_r, val_nxt;
  logic [TGD_BYTE_W-1:0]     hist1_r, hist1_nxt;
  logic [TGD_BYTE_W-1:0]     hist2_r, hist2_nxt;
  logic [TGD_BYTE_W-1:0]     byte_r, byte_nxt;
  logic [TGD_BYTE_W-1:0]     sub_rd_data;
  logic [TGD_BYTE_W-1:0]     raw_byte;
  logic [TGD_BYTE_W-1:0]     cur_byte;
  logic                      sub_rd_en;

  tgd_ram #(
    .WIDTH (TGD_BYTE_W),
    .DEPTH (TGD_SUB_DEPTH)
  ) u_sub_ram (
    .clk     (clk),
    .wr_en   (sub_wr.we),
    .wr_addr (sub_wr.addr),
    .wr_data (sub_wr.data),
    .rd_en   (sub_rd_en),
    .rd_addr (cur_byte),
    .rd_data (sub_rd_data)
  );

  // Clear mask positions read as zero; literal tiles use every position.
  // The XOR chain skips the first two bytes of each 16-byte half.
  always_comb begin
    if (mode_r != CMD_LITERAL && !mask_r[pos_r]) begin
      raw_byte = '0;
    end else begin
      raw_byte = tile_rd_data;
    end
    if (mode_r == CMD_MASK_XOR && pos_r[3:1] != 3'd0) begin
      cur_byte = raw_byte ^ hist2_r;
    end else begin
      cur_byte = raw_byte;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      E_IDLE: begin
        if (req.start) begin
          state_nxt = E_READ;
        end
      end
      E_READ: state_nxt = E_CALC;
      E_CALC: state_nxt = E_LOAD;
      E_LOAD: state_nxt = E_HOLD;
      E_HOLD: begin
        if (out_ready) begin
          state_nxt = (pos_r == TGD_LAST_POS) ? E_IDLE : E_READ;
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_comb begin
    pos_nxt      = pos_r;
    mode_nxt     = mode_r;
    mask_nxt     = mask_r;
    val_nxt      = val_r;
    hist1_nxt    = hist1_r;
    hist2_nxt    = hist2_r;
    byte_nxt     = byte_r;
    tile_rd_en   = 1'b0;
    tile_rd_addr = pos_r;
    sub_rd_en    = 1'b0;
    busy         = 1'b1;
    out_valid    = 1'b0;
    case (state_r)
      E_IDLE: begin
        busy = 1'b0;
        if (req.start) begin
          pos_nxt  = '0;
          mode_nxt = req.mode;
          mask_nxt = req.mask;
        end
      end
      E_READ: begin
        tile_rd_en = 1'b1;
      end
      E_CALC: begin
        sub_rd_en = 1'b1;
        val_nxt   = cur_byte;
        hist1_nxt = cur_byte;
        hist2_nxt = hist1_r;
      end
      E_LOAD: begin
        byte_nxt = sub_enable ? sub_rd_data : val_r;
      end
      E_HOLD: begin
        out_valid = 1'b1;
        if (out_ready && pos_r != TGD_LAST_POS) begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      default: busy = 1'b0;
    endcase
  end

  assign out_tile_byte    = byte_r;
  assign out_byte_index   = pos_r;
  assign out_last_of_tile = (pos_r == TGD_LAST_POS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    pos_r   <= pos_nxt;
    mode_r  <= mode_nxt;
    mask_r  <= mask_nxt;
    val_r   <= val_nxt;
    hist1_r <= hist1_nxt;
    hist2_r <= hist2_nxt;
    byte_r  <= byte_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/tile_graphic_decompressor.sv =====
`default_nettype none
// Channel  Direction  Beat contents
// in_      input      operation, command, data_byte, table_index
// out_     output     tile_byte, byte_index, last_of_tile
// cfg_     input      substitution enable, written when cfg_we is high
//
// Input beats are accepted while in_ready is high. After a masked tile's last mask
// byte or literal, the fill pointer steps over clear mask bits one position per cycle,
// then resumes intake at a set mask bit, or starts tile output past the last position.
// A finished tile streams out beat by beat through states READ, CALC, LOAD and HOLD;
// the tile RAM and substitution RAM reads run in series, and HOLD waits for out_ready.
// in_ready is low while a tile is skipped or emitted. Reset is synchronous.
module tile_graphic_decompressor
  import tgd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_operation,
  input  wire logic [1:0]            in_command,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic [7:0]            in_table_index,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_tile_byte,
  output logic [4:0]                 out_byte_index,
  output logic                       out_last_of_tile,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_wdata
);

  tgd_state_t state_r, state_nxt;

  logic                      sub_en_r;
  logic [1:0]                mode_r, mode_nxt;
  logic [TGD_TILE_AW:0]      fill_r, fill_nxt;
  logic [2:0]                mbs_r, mbs_nxt;
  logic [TGD_TILE_BYTES-1:0] mask_r, mask_nxt;
  logic                      open_r, open_nxt;

  logic                      accept;
  logic                      tile_wr_en;
  logic                      tile_rd_en;
  logic [TGD_TILE_AW-1:0]    tile_rd_addr;
  logic [TGD_BYTE_W-1:0]     tile_rd_data;
  logic                      emit_busy;
  tgd_emit_req_t             emit_req;
  tgd_sub_wr_t               sub_wr;

  assign accept = in_valid && in_ready;

  tgd_ram #(
    .WIDTH (TGD_BYTE_W),
    .DEPTH (TGD_TILE_BYTES)
  ) u_tile_ram (
    .clk     (clk),
    .wr_en   (tile_wr_en),
    .wr_addr (fill_r[TGD_TILE_AW-1:0]),
    .wr_data (in_data_byte),
    .rd_en   (tile_rd_en),
    .rd_addr (tile_rd_addr),
    .rd_data (tile_rd_data)
  );

  tgd_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .req              (emit_req),
    .sub_wr           (sub_wr),
    .sub_enable       (sub_en_r),
    .busy             (emit_busy),
    .tile_rd_en       (tile_rd_en),
    .tile_rd_addr     (tile_rd_addr),
    .tile_rd_data     (tile_rd_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tile_byte    (out_tile_byte),
    .out_byte_index   (out_byte_index),
    .out_last_of_tile (out_last_of_tile)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_TILE_CMD && in_command == CMD_ZERO) begin
            state_nxt = ST_EMIT;
          end else if (in_operation == OP_DATA && open_r) begin
            if (mode_r == CMD_LITERAL) begin
              if (fill_r == {1'b0, TGD_LAST_POS}) begin
                state_nxt = ST_EMIT;
              end
            end else if (mbs_r != MASK_BYTES) begin
              if (mbs_r == MASK_BYTES - 3'd1) begin
                state_nxt = ST_SKIP;
              end
            end else begin
              state_nxt = ST_SKIP;
            end
          end
        end
      end
      ST_SKIP: begin
        if (fill_r[TGD_TILE_AW]) begin
          state_nxt = ST_EMIT;
        end else if (mask_r[fill_r[TGD_TILE_AW-1:0]]) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!emit_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and tile bookkeeping.
  always_comb begin
    in_ready       = 1'b0;
    tile_wr_en     = 1'b0;
    mode_nxt       = mode_r;
    fill_nxt       = fill_r;
    mbs_nxt        = mbs_r;
    mask_nxt       = mask_r;
    open_nxt       = open_r;
    emit_req.start = 1'b0;
    emit_req.mode  = mode_r;
    emit_req.mask  = mask_r;
    sub_wr.we      = 1'b0;
    sub_wr.addr    = in_table_index;
    sub_wr.data    = in_data_byte;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          case (in_operation)
            OP_TABLE_WR: sub_wr.we = 1'b1;
            OP_TILE_CMD: begin
              mode_nxt = in_command;
              fill_nxt = '0;
              mbs_nxt  = '0;
              mask_nxt = '0;
              open_nxt = 1'b1;
              if (in_command == CMD_ZERO) begin
                // All mask bits clear, so every byte reads as zero.
                emit_req.start = 1'b1;
                emit_req.mode  = CMD_ZERO;
                emit_req.mask  = '0;
                open_nxt       = 1'b0;
              end
            end
            OP_DATA: begin
              if (open_r) begin
                if (mode_r == CMD_LITERAL) begin
                  tile_wr_en = 1'b1;
                  fill_nxt   = fill_r + 1'b1;
                  if (fill_r == {1'b0, TGD_LAST_POS}) begin
                    emit_req.start = 1'b1;
                    open_nxt       = 1'b0;
                  end
                end else if (mbs_r != MASK_BYTES) begin
                  mask_nxt[{mbs_r[1:0], 3'b000} +: 8] =
                    mask_r[{mbs_r[1:0], 3'b000} +: 8] | in_data_byte;
                  mbs_nxt = mbs_r + 3'd1;
                end else begin
                  tile_wr_en = 1'b1;
                  fill_nxt   = fill_r + 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SKIP: begin
        if (fill_r[TGD_TILE_AW]) begin
          emit_req.start = 1'b1;
          open_nxt       = 1'b0;
        end else if (!mask_r[fill_r[TGD_TILE_AW-1:0]]) begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      sub_en_r <= 1'b0;
      mode_r   <= CMD_ZERO;
      fill_r   <= '0;
      mbs_r    <= '0;
      mask_r   <= '0;
      open_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        sub_en_r <= cfg_wdata;
      end
      mode_r <= mode_nxt;
      fill_r <= fill_nxt;
      mbs_r  <= mbs_nxt;
      mask_r <= mask_nxt;
      open_r <= open_nxt;
    end
  end

endmodule
`default_nettype wire
